@@ rtl/kcc_pkg.sv @@
// ----------------------------------------------------------------------------
// kcc_pkg
// Shared types and constants for the key click classifier.
// ----------------------------------------------------------------------------
package kcc_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;
	localparam int THR_W  = 8;

	localparam logic [THR_W-1:0] LONG_PRESS_RESET  = 8'd50;
	localparam logic [THR_W-1:0] DOUBLE_WAIT_RESET = 8'd25;
	localparam logic             PRESSED_LVL_RESET = 1'b0;

	typedef enum logic [1:0] {
		REG_LONG_PRESS  = 2'd0,
		REG_DOUBLE_WAIT = 2'd1,
		REG_PRESSED_LVL = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE     = 3'd0,
		ST_DEBOUNCE = 3'd1,
		ST_PRESSED  = 3'd2,
		ST_LONG     = 3'd3,
		ST_WAIT     = 3'd4,
		ST_SECOND   = 3'd5
	} key_state_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_SINGLE = 2'd1,
		EV_DOUBLE = 2'd2,
		EV_LONG   = 2'd3
	} press_event_t;

	typedef struct packed {
		logic [THR_W-1:0] long_press_ticks;
		logic [THR_W-1:0] double_wait_ticks;
		logic             pressed_level;
	} cfg_t;

endpackage

@@ rtl/kcc_cfg.sv @@
// ----------------------------------------------------------------------------
// kcc_cfg
// APB register file: press thresholds and active pin level.
// ----------------------------------------------------------------------------
module kcc_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [kcc_pkg::ADDR_W-1:0] paddr,
	input  logic [kcc_pkg::DATA_W-1:0] pwdata,
	output logic [kcc_pkg::DATA_W-1:0] prdata,
	output logic                       pready,
	output kcc_pkg::cfg_t              cfg
);

	kcc_pkg::cfg_t     cfg_q;
	kcc_pkg::reg_idx_t reg_idx;
	logic              wr_en;

	assign reg_idx = kcc_pkg::reg_idx_t'(paddr[kcc_pkg::ADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ticks  <= kcc_pkg::LONG_PRESS_RESET;
			cfg_q.double_wait_ticks <= kcc_pkg::DOUBLE_WAIT_RESET;
			cfg_q.pressed_level     <= kcc_pkg::PRESSED_LVL_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				kcc_pkg::REG_LONG_PRESS: begin
					cfg_q.long_press_ticks <= pwdata[kcc_pkg::THR_W-1:0];
				end
				kcc_pkg::REG_DOUBLE_WAIT: begin
					cfg_q.double_wait_ticks <= pwdata[kcc_pkg::THR_W-1:0];
				end
				kcc_pkg::REG_PRESSED_LVL: begin
					cfg_q.pressed_level <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_idx)
			kcc_pkg::REG_LONG_PRESS: begin
				prdata[kcc_pkg::THR_W-1:0] = cfg_q.long_press_ticks;
			end
			kcc_pkg::REG_DOUBLE_WAIT: begin
				prdata[kcc_pkg::THR_W-1:0] = cfg_q.double_wait_ticks;
			end
			kcc_pkg::REG_PRESSED_LVL: begin
				prdata[0] = cfg_q.pressed_level;
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

@@ rtl/kcc_step.sv @@
// ----------------------------------------------------------------------------
// kcc_step
// Next state, counter and event for one key on one sampling tick.
// ----------------------------------------------------------------------------
module kcc_step #(
	parameter int COUNT_WIDTH = 8
) (
	input  kcc_pkg::cfg_t          cfg,
	input  logic                   pin_level,
	input  kcc_pkg::key_state_t    state_in,
	input  logic [COUNT_WIDTH-1:0] count_in,
	output kcc_pkg::key_state_t    state_out,
	output logic [COUNT_WIDTH-1:0] count_out,
	output kcc_pkg::press_event_t  press_event
);

	localparam int CMP_W = (COUNT_WIDTH > kcc_pkg::THR_W) ? COUNT_WIDTH : kcc_pkg::THR_W;
	localparam logic [CMP_W-1:0] CNT_MAX = CMP_W'((1 << COUNT_WIDTH) - 1);

	logic             press;
	logic [CMP_W-1:0] cnt_ext;
	logic [CMP_W-1:0] long_thr;
	logic [CMP_W-1:0] wait_thr;
	logic [CMP_W-1:0] long_lim;
	logic [CMP_W-1:0] wait_lim;
	logic             long_hit;
	logic             wait_hit;

	// thresholds clip to what the counter can reach
	assign press    = (pin_level == cfg.pressed_level);
	assign cnt_ext  = CMP_W'(count_in);
	assign long_thr = CMP_W'(cfg.long_press_ticks);
	assign wait_thr = CMP_W'(cfg.double_wait_ticks);
	assign long_lim = (long_thr > CNT_MAX) ? CNT_MAX : long_thr;
	assign wait_lim = (wait_thr > CNT_MAX) ? CNT_MAX : wait_thr;
	assign long_hit = (cnt_ext >= long_lim);
	assign wait_hit = (cnt_ext >= wait_lim);

	// next state and counter
	always_comb begin
		state_out = state_in;
		count_out = count_in;
		case (state_in)
			kcc_pkg::ST_DEBOUNCE: begin
				state_out = press ? kcc_pkg::ST_PRESSED : kcc_pkg::ST_IDLE;
			end
			kcc_pkg::ST_PRESSED: begin
				if (press && long_hit) begin
					state_out = kcc_pkg::ST_LONG;
					count_out = '0;
				end else if (press) begin
					count_out = count_in + 1'b1;
				end else begin
					state_out = kcc_pkg::ST_WAIT;
					count_out = '0;
				end
			end
			kcc_pkg::ST_LONG: begin
				count_out = '0;
				if (!press) begin
					state_out = kcc_pkg::ST_IDLE;
				end
			end
			kcc_pkg::ST_WAIT: begin
				if (!press && wait_hit) begin
					state_out = kcc_pkg::ST_IDLE;
					count_out = '0;
				end else if (!press) begin
					count_out = count_in + 1'b1;
				end else begin
					state_out = kcc_pkg::ST_SECOND;
					count_out = '0;
				end
			end
			kcc_pkg::ST_SECOND: begin
				if (press && long_hit) begin
					state_out = kcc_pkg::ST_LONG;
					count_out = '0;
				end else if (press) begin
					count_out = count_in + 1'b1;
				end else begin
					state_out = kcc_pkg::ST_IDLE;
					count_out = '0;
				end
			end
			default: begin
				// idle, and unused codes recover as idle
				state_out = press ? kcc_pkg::ST_DEBOUNCE : kcc_pkg::ST_IDLE;
			end
		endcase
	end

	// event
	always_comb begin
		press_event = kcc_pkg::EV_NONE;
		case (state_in)
			kcc_pkg::ST_LONG: begin
				if (!press) begin
					press_event = kcc_pkg::EV_LONG;
				end
			end
			kcc_pkg::ST_WAIT: begin
				if (!press && wait_hit) begin
					press_event = kcc_pkg::EV_SINGLE;
				end
			end
			kcc_pkg::ST_SECOND: begin
				if (press && long_hit) begin
					press_event = kcc_pkg::EV_SINGLE;
				end else if (!press) begin
					press_event = kcc_pkg::EV_DOUBLE;
				end
			end
			default: begin
				press_event = kcc_pkg::EV_NONE;
			end
		endcase
	end

endmodule

@@ rtl/key_click_classifier.sv @@
// ----------------------------------------------------------------------------
// key_click_classifier
// Per-key single, double and long press detector fed by sampling-tick beats.
// ----------------------------------------------------------------------------
// Path: a beat lands in the input register; once the output slot is free or
//   being taken, its event is registered. One beat per cycle unless a full
//   output slot is held; the per-key state read, update and write back all
//   happen in the same cycle, between the two registers.
// Reset: every key returns to idle with a zero counter, registers to defaults.
module key_click_classifier #(
	parameter int NUM_KEYS    = 4,
	parameter int COUNT_WIDTH = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 key_index,
	input  logic                       pin_level,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [1:0]                 key_number,
	output logic [1:0]                 press_event,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [kcc_pkg::ADDR_W-1:0] paddr,
	input  logic [kcc_pkg::DATA_W-1:0] pwdata,
	output logic [kcc_pkg::DATA_W-1:0] prdata,
	output logic                       pready
);

	localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int SEL_W = (IDX_W > 2) ? IDX_W : 2;

	kcc_pkg::cfg_t          cfg;
	kcc_pkg::key_state_t    state_q [NUM_KEYS];
	logic [COUNT_WIDTH-1:0] count_q [NUM_KEYS];

	logic                   valid_s1;
	logic [1:0]             key_s1;
	logic                   pin_s1;
	logic                   out_valid_q;
	logic [1:0]             key_number_q;
	kcc_pkg::press_event_t  press_event_q;

	logic                   in_fire;
	logic                   advance;
	logic [SEL_W-1:0]       key_sel;
	logic [IDX_W-1:0]       idx;
	logic                   in_range;
	kcc_pkg::key_state_t    nxt_state;
	logic [COUNT_WIDTH-1:0] nxt_count;
	kcc_pkg::press_event_t  step_event;

	kcc_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign key_sel  = SEL_W'(key_s1);
	assign idx      = key_sel[IDX_W-1:0];
	assign in_range = (32'(key_s1) < 32'(NUM_KEYS));

	kcc_step #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_step (
		.cfg         (cfg),
		.pin_level   (pin_s1),
		.state_in    (state_q[idx]),
		.count_in    (count_q[idx]),
		.state_out   (nxt_state),
		.count_out   (nxt_count),
		.press_event (step_event)
	);

	// input register drains whenever the output slot is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;
	assign in_fire  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_s1 <= key_index;
			pin_s1 <= pin_level;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYS; i++) begin
				state_q[i] <= kcc_pkg::ST_IDLE;
				count_q[i] <= '0;
			end
		end else if (advance && in_range) begin
			state_q[idx] <= nxt_state;
			count_q[idx] <= nxt_count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			key_number_q  <= key_s1;
			press_event_q <= in_range ? step_event : kcc_pkg::EV_NONE;
		end
	end

	assign out_valid   = out_valid_q;
	assign key_number  = key_number_q;
	assign press_event = press_event_q;

	// keys beyond the configured count never report an event
	a_no_event_out_of_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (press_event_q != kcc_pkg::EV_NONE) |->
			(32'(key_number_q) < 32'(NUM_KEYS)))
		else $error("event reported for a key beyond NUM_KEYS");

	// the updated state lands in the entry of the key just processed
	a_state_writeback: assert property (@(posedge clk) disable iff (!arst_n)
		advance && in_range |=> state_q[$past(idx)] == $past(nxt_state))
		else $error("key state not written back");

	// the long-held state always carries a cleared counter
	a_long_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		advance && in_range && (nxt_state == kcc_pkg::ST_LONG) |-> (nxt_count == '0))
		else $error("long-held key with nonzero counter");

	// an empty output slot never blocks the input register
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty output register");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for key_click_classifier: gesture-shaped tick streams on
// all four keys across several register settings, each event predicted per
// key and checked in order, with random gaps on both sides of the handshake.
// ----------------------------------------------------------------------------
module tb;

	localparam int LIMIT = 100000;
	localparam int AW    = kcc_pkg::ADDR_W;
	localparam int DW    = kcc_pkg::DATA_W;

	typedef struct {
		logic [1:0] key;
		logic       lvl;
	} tick_t;

	typedef struct {
		logic [1:0]            key;
		kcc_pkg::press_event_t ev;
	} click_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          key_index;
	logic                pin_level;
	logic                out_valid;
	logic                out_ready;
	logic [1:0]          key_number;
	logic [1:0]          press_event;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [AW-1:0]       paddr;
	logic [DW-1:0]       pwdata;
	logic [DW-1:0]       prdata;
	logic                pready;

	// tick plan, predicted events, predictor state
	tick_t               tick_plan[$];
	click_t              click_q[$];
	kcc_pkg::key_state_t key_st[4] = '{default: kcc_pkg::ST_IDLE};
	logic [7:0]          hold_ticks[4] = '{default: 8'd0};
	logic [7:0]          cfg_long;
	logic [7:0]          cfg_wait;
	logic                cfg_pressed;

	int  tx_idle_pct;
	int  rx_idle_pct;
	int  noise_pct;
	bit  in_fire;
	int  mismatches;
	int  ticks_taken;
	int  clicks_seen;
	int  ev_seen[4];
	int  stall_left;
	bit  stall_done;
	int  settings_run;

	key_click_classifier dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.key_index   (key_index),
		.pin_level   (pin_level),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_number  (key_number),
		.press_event (press_event),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic kcc_pkg::press_event_t classify_tick(logic [1:0] k, logic lvl);
		kcc_pkg::press_event_t ev;
		logic                  press;
		ev = kcc_pkg::EV_NONE;
		press = (lvl == cfg_pressed);
		case (key_st[k])
			kcc_pkg::ST_DEBOUNCE: begin
				key_st[k] = press ? kcc_pkg::ST_PRESSED : kcc_pkg::ST_IDLE;
			end
			kcc_pkg::ST_PRESSED: begin
				if (press && hold_ticks[k] >= cfg_long) begin
					key_st[k] = kcc_pkg::ST_LONG;
					hold_ticks[k] = '0;
				end else if (press) begin
					hold_ticks[k] = hold_ticks[k] + 8'd1;
				end else begin
					key_st[k] = kcc_pkg::ST_WAIT;
					hold_ticks[k] = '0;
				end
			end
			kcc_pkg::ST_LONG: begin
				// stays put while held, long press reported on release
				hold_ticks[k] = '0;
				if (!press) begin
					key_st[k] = kcc_pkg::ST_IDLE;
					ev = kcc_pkg::EV_LONG;
				end
			end
			kcc_pkg::ST_WAIT: begin
				if (!press && hold_ticks[k] >= cfg_wait) begin
					key_st[k] = kcc_pkg::ST_IDLE;
					hold_ticks[k] = '0;
					ev = kcc_pkg::EV_SINGLE;
				end else if (!press) begin
					hold_ticks[k] = hold_ticks[k] + 8'd1;
				end else begin
					key_st[k] = kcc_pkg::ST_SECOND;
					hold_ticks[k] = '0;
				end
			end
			kcc_pkg::ST_SECOND: begin
				// held second press: single click now, long press on release
				if (press && hold_ticks[k] >= cfg_long) begin
					key_st[k] = kcc_pkg::ST_LONG;
					hold_ticks[k] = '0;
					ev = kcc_pkg::EV_SINGLE;
				end else if (press) begin
					hold_ticks[k] = hold_ticks[k] + 8'd1;
				end else begin
					key_st[k] = kcc_pkg::ST_IDLE;
					hold_ticks[k] = '0;
					ev = kcc_pkg::EV_DOUBLE;
				end
			end
			default: begin
				key_st[k] = press ? kcc_pkg::ST_DEBOUNCE : kcc_pkg::ST_IDLE;
			end
		endcase
		return ev;
	endfunction

	task automatic note_mismatch(string tag, logic [DW-1:0] want, logic [DW-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] %s: expected %h, got %h", $realtime, tag, want, got);
	endtask

	// sampling side: acceptance, prediction, event check
	always @(posedge clk) begin
		click_t want;
		in_fire = arst_n && in_valid && in_ready;
		if (in_fire) begin
			want.key = key_index;
			want.ev = classify_tick(key_index, pin_level);
			click_q.push_back(want);
			ticks_taken++;
		end
		if (arst_n && out_valid && out_ready) begin
			clicks_seen++;
			if (click_q.size() == 0) begin
				note_mismatch("beat with nothing predicted (key/event)", '0,
					DW'({key_number, press_event}));
			end else begin
				want = click_q.pop_front();
				ev_seen[want.ev]++;
				if (key_number !== want.key || press_event !== want.ev)
					note_mismatch("key/event", DW'({want.key, want.ev}),
						DW'({key_number, press_event}));
			end
		end
	end

	// tick driver
	always @(negedge clk) begin
		if (!in_valid || in_fire) begin
			if (tick_plan.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
				in_valid <= 1'b1;
				key_index <= tick_plan[0].key;
				pin_level <= tick_plan[0].lvl;
				void'(tick_plan.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// event receiver, with one long hold-off to back the block up
	always @(negedge clk) begin
		if (!stall_done && clicks_seen >= 350) begin
			stall_done = 1'b1;
			stall_left = 300;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic add_tick(logic [1:0] k, logic lvl);
		tick_t t;
		t.key = k;
		t.lvl = lvl;
		tick_plan.push_back(t);
	endtask

	// pressed / released tick on key k, sometimes with a stray tick on another key
	task automatic add_press(logic [1:0] k, bit pressed);
		if ($urandom_range(0, 99) < noise_pct)
			add_tick(k + 2'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
		add_tick(k, pressed ? cfg_pressed : ~cfg_pressed);
	endtask

	function automatic int pick_len(int thr);
		int lo;
		lo = (thr > 2) ? thr - 2 : 0;
		case ($urandom_range(0, 3))
			0, 1:    return $urandom_range(0, 3);
			2:       return $urandom_range(lo, thr + 3);
			default: return $urandom_range(0, thr + 4);
		endcase
	endfunction

	task automatic add_gesture();
		logic [1:0] k;
		int         kind;
		k = 2'($urandom_range(0, 3));
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			repeat ($urandom_range(3, 12))
				add_tick(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
		end else begin
			repeat ($urandom_range(0, 2)) add_press(k, 1'b0);
			repeat (1 + pick_len(cfg_long)) add_press(k, 1'b1);
			repeat (pick_len(cfg_wait)) add_press(k, 1'b0);
			if (kind >= 5) begin
				repeat (pick_len(cfg_long)) add_press(k, 1'b1);
				repeat (1 + pick_len(cfg_wait)) add_press(k, 1'b0);
			end
		end
	endtask

	task automatic plan_random(int count);
		int stop_at;
		stop_at = tick_plan.size() + count;
		while (tick_plan.size() < stop_at)
			add_gesture();
		// trim the last gesture so the phase adds exactly count ticks
		while (tick_plan.size() > stop_at)
			void'(tick_plan.pop_back());
	endtask

	task automatic drain();
		while (!(tick_plan.size() == 0 && !in_valid && click_q.size() == 0))
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_reg(kcc_pkg::reg_idx_t r, logic [7:0] v);
		logic [DW-1:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= AW'(r) << 2;
		pwdata <= DW'(v);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (r)
			kcc_pkg::REG_LONG_PRESS:  cfg_long = v;
			kcc_pkg::REG_DOUBLE_WAIT: cfg_wait = v;
			default:                  cfg_pressed = v[0];
		endcase
		if (rd !== DW'(v))
			note_mismatch("register read back", DW'(v), rd);
	endtask

	task automatic set_all(logic [7:0] lp, logic [7:0] dw, logic pl);
		set_reg(kcc_pkg::REG_LONG_PRESS, lp);
		set_reg(kcc_pkg::REG_DOUBLE_WAIT, dw);
		set_reg(kcc_pkg::REG_PRESSED_LVL, 8'(pl));
		settings_run++;
	endtask

	initial begin : watchdog
		int n;
		n = 0;
		while (n < LIMIT) begin
			@(posedge clk);
			n++;
		end
		$display("key_click_classifier: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		key_index = '0;
		pin_level = 1'b0;
		out_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_long = kcc_pkg::LONG_PRESS_RESET;
		cfg_wait = kcc_pkg::DOUBLE_WAIT_RESET;
		cfg_pressed = kcc_pkg::PRESSED_LVL_RESET;
		tx_idle_pct = 25;
		rx_idle_pct = 69;
		noise_pct = 20;
		settings_run = 1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset thresholds
		plan_random(200);
		drain();

		// short thresholds, press level low: one of each gesture, then random
		set_all(8'd2, 8'd1, 1'b0);
		noise_pct = 0;
		add_press(2'd3, 1); add_press(2'd3, 1);
		add_press(2'd3, 0); add_press(2'd3, 0); add_press(2'd3, 0);
		add_press(2'd0, 1); add_press(2'd0, 1);
		add_press(2'd0, 0); add_press(2'd0, 1); add_press(2'd0, 0);
		repeat (5) add_press(2'd1, 1);
		add_press(2'd1, 0);
		add_press(2'd2, 1); add_press(2'd2, 1); add_press(2'd2, 0);
		repeat (4) add_press(2'd2, 1);
		add_press(2'd2, 0);
		noise_pct = 20;
		plan_random(230);
		drain();

		tx_idle_pct = 69;
		rx_idle_pct = 25;
		set_all(8'd1, 8'd1, 1'b1);
		plan_random(250);
		drain();

		set_all(8'd255, 8'd255, 1'b0);
		plan_random(600);
		drain();

		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_all(8'd7, 8'd5, 1'b1);
		plan_random(200);
		drain();

		set_all(8'($urandom_range(1, 16)), 8'($urandom_range(1, 16)), 1'($urandom_range(0, 1)));
		plan_random(150);
		drain();

		$display("%0d ticks over %0d register settings on 4 keys, with one long output stall",
			ticks_taken, settings_run);
		$display("events seen: %0d none, %0d single, %0d double, %0d long",
			ev_seen[kcc_pkg::EV_NONE], ev_seen[kcc_pkg::EV_SINGLE],
			ev_seen[kcc_pkg::EV_DOUBLE], ev_seen[kcc_pkg::EV_LONG]);
		if (mismatches == 0 && click_q.size() == 0) begin
			$display("key_click_classifier: match");
		end else begin
			$display("key_click_classifier: mismatch");
		end
		$finish;
	end

endmodule
